@@ src/lbpg_pkg.sv @@
// Package for the LED backlight pattern generator.
// Holds field widths, register indexes and reset values, and the queue depth.
// No dependencies.
package lbpg_pkg;

  localparam int unsigned LED_COUNT_DEF = 32;
  localparam int unsigned MAX_RESULTS   = 32;

  localparam int unsigned TIME_W     = 64;
  localparam int unsigned INTERVAL_W = 20;
  localparam int unsigned SHIFT_W    = 3;
  localparam int unsigned LED_IDX_W  = 5;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHIFT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd2;

  // Pattern codes.
  localparam logic PAT_SNAKE   = 1'b0;
  localparam logic PAT_RAINBOW = 1'b1;

  // Reset values.
  localparam logic                  PATTERN_RST  = PAT_RAINBOW;
  localparam logic [SHIFT_W-1:0]    SHIFT_RST    = 3'd3;
  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 20'd33000;

  localparam int unsigned Q_DEPTH = 2;

endpackage

@@ src/led_backlight_pattern_generator.sv @@
// Top level of the LED backlight pattern generator: config registers and wiring.
// Instantiates lbpg_front, lbpg_queue and lbpg_back; depends on lbpg_pkg.
//
//   channel  direction  handshake                  payload
//   in       input      in_valid_i / in_ready_o    now_us_i, frame_sent_i
//   out      output     out_valid_o / out_ready_i  led_index_o, red_o, green_o,
//                                                  blue_o, last_led_o
//   cfg      input      cfg_we_i (no wait)         cfg_index_i, cfg_wdata_i
//
// The front end checks the frame interval of each input beat with one 64-bit
// subtract and compare. A frame yields min(LED_COUNT, 32) output beats at one per
// cycle unless the output stalls, paced by the LED counter in the back end; the
// first beat passes the queue, the LED counter and the output register. Frames
// follow each other without a gap while the queue holds a command.
// Reset clears time, phase, queue and output valid; no clearing pass is needed.
// A stall on the output only backs up the queue; in_ready_o drops when it is full.
module led_backlight_pattern_generator #(
  parameter int unsigned LED_COUNT = lbpg_pkg::LED_COUNT_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [lbpg_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [lbpg_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [lbpg_pkg::TIME_W-1:0]         now_us_i,
  input  logic                                frame_sent_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [lbpg_pkg::LED_IDX_W-1:0]      led_index_o,
  output logic [lbpg_pkg::CH_W-1:0]           red_o,
  output logic [lbpg_pkg::CH_W-1:0]           green_o,
  output logic [lbpg_pkg::CH_W-1:0]           blue_o,
  output logic                                last_led_o
);
  import lbpg_pkg::*;

  localparam int unsigned PHASE_W = $clog2(LED_COUNT);

  // Configuration registers; written by user only while block idle; unchecked.
  logic                  pattern_q;
  logic [SHIFT_W-1:0]    shift_q;
  logic [INTERVAL_W-1:0] interval_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q  <= PATTERN_RST;
      shift_q    <= SHIFT_RST;
      interval_q <= INTERVAL_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PATTERN:  pattern_q  <= cfg_wdata_i[0];
        CFG_SHIFT:    shift_q    <= cfg_wdata_i[SHIFT_W-1:0];
        CFG_INTERVAL: interval_q <= cfg_wdata_i[INTERVAL_W-1:0];
        default:      ;  // unmapped index: drop the write
      endcase
    end
  end

  // Front end -> queue -> back end.
  logic               push, q_full, q_valid, pop;
  logic [PHASE_W-1:0] push_phase, q_phase;

  lbpg_front #(
    .LED_COUNT (LED_COUNT),
    .PHASE_W   (PHASE_W)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .now_us_i     (now_us_i),
    .frame_sent_i (frame_sent_i),
    .interval_i   (interval_q),
    .push_o       (push),
    .push_phase_o (push_phase),
    .q_full_i     (q_full)
  );

  lbpg_queue #(
    .DATA_W (PHASE_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_phase),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_data_o  (q_phase)
  );

  lbpg_back #(
    .LED_COUNT (LED_COUNT),
    .PHASE_W   (PHASE_W)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_phase_i   (q_phase),
    .pop_o       (pop),
    .pattern_i   (pattern_q),
    .shift_i     (shift_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .led_index_o (led_index_o),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o),
    .last_led_o  (last_led_o)
  );

endmodule

@@ src/lbpg_front.sv @@
// Front end: accepts time stamps, checks the frame interval, keeps the phase.
// Pushes one frame command (the phase to draw) into the queue per frame.
// Depends on lbpg_pkg.
module lbpg_front #(
  parameter int unsigned LED_COUNT = lbpg_pkg::LED_COUNT_DEF,
  parameter int unsigned PHASE_W   = $clog2(LED_COUNT)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [lbpg_pkg::TIME_W-1:0]         now_us_i,
  input  logic                                frame_sent_i,
  input  logic [lbpg_pkg::INTERVAL_W-1:0]     interval_i,
  output logic                                push_o,
  output logic [PHASE_W-1:0]                  push_phase_o,
  input  logic                                q_full_i
);
  import lbpg_pkg::*;

  logic [TIME_W-1:0]  last_q, last_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [TIME_W-1:0]  elapsed;
  logic               fire, trig;

  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && in_ready_o;
  assign elapsed    = now_us_i - last_q;
  assign trig       = elapsed >= TIME_W'(interval_i);

  assign push_o       = fire && trig;
  assign push_phase_o = phase_q;

  always_comb begin
    last_d  = last_q;
    phase_d = phase_q;
    if (push_o) begin
      last_d = now_us_i;
      if (frame_sent_i) begin
        if (phase_q == PHASE_W'(LED_COUNT - 1)) begin
          phase_d = '0;
        end else begin
          phase_d = phase_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q  <= '0;
      phase_q <= '0;
    end else begin
      last_q  <= last_d;
      phase_q <= phase_d;
    end
  end

`ifndef SYNTHESIS
  a_phase_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q <= PHASE_W'(LED_COUNT - 1))
    else $error("phase out of range");
  a_time_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> last_q == $past(now_us_i))
    else $error("frame time not recorded");
  a_early_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !trig) |=> ($stable(phase_q) && $stable(last_q)))
    else $error("early beat changed state");
`endif

endmodule

@@ src/lbpg_queue.sv @@
// Short command queue between front end and back end.
// Holds frame phases; push and pop may happen in the same cycle.
// Depends on lbpg_pkg.
module lbpg_queue #(
  parameter int unsigned DATA_W = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] pop_data_o
);
  import lbpg_pkg::*;

  localparam int unsigned PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  logic [DATA_W-1:0] mem_q [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;

  assign full_o     = cnt_q == CNT_W'(Q_DEPTH);
  assign valid_o    = cnt_q != '0;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ src/lbpg_back.sv @@
// Back end: walks a frame's LEDs to an output reg, one color per cycle unless stalled.
// Hue wheel sector and fraction come from an elaboration-time table per position.
// Depends on lbpg_pkg.
module lbpg_back #(
  parameter int unsigned LED_COUNT = lbpg_pkg::LED_COUNT_DEF,
  parameter int unsigned PHASE_W   = $clog2(LED_COUNT)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  input  logic [PHASE_W-1:0]                q_phase_i,
  output logic                              pop_o,
  input  logic                              pattern_i,
  input  logic [lbpg_pkg::SHIFT_W-1:0]      shift_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [lbpg_pkg::LED_IDX_W-1:0]    led_index_o,
  output logic [lbpg_pkg::CH_W-1:0]         red_o,
  output logic [lbpg_pkg::CH_W-1:0]         green_o,
  output logic [lbpg_pkg::CH_W-1:0]         blue_o,
  output logic                              last_led_o
);
  import lbpg_pkg::*;

  localparam int unsigned NUM_OUT = (LED_COUNT < MAX_RESULTS) ? LED_COUNT : MAX_RESULTS;
  localparam int unsigned CNT_W   = $clog2(NUM_OUT);
  localparam logic [CH_W-1:0] FULL = 8'd255;

  // Hue wheel table: sector and fraction for each wheel position.
  logic [2:0]      sec_tbl  [LED_COUNT];
  logic [CH_W-1:0] frac_tbl [LED_COUNT];

  for (genvar g = 0; g < LED_COUNT; g++) begin : g_hue
    localparam int unsigned P = 6 * g;
    assign sec_tbl[g]  = 3'(P / LED_COUNT);
    assign frac_tbl[g] = CH_W'((255 * (P % LED_COUNT)) / LED_COUNT);
  end

  logic               busy_q, busy_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic               advance, emit, last_beat;

  logic [PHASE_W:0]   sum;
  logic [PHASE_W-1:0] x;
  logic [2:0]         sec;
  logic [CH_W-1:0]    f, rr, gg, bb, r_c, g_c, b_c;

  logic                 out_vld_q;
  logic [LED_IDX_W-1:0] idx_out_q;
  logic [CH_W-1:0]      r_q, g_q, b_q;
  logic                 last_q;

  assign advance   = !out_vld_q || out_ready_i;
  assign emit      = busy_q && advance;
  assign last_beat = idx_q == CNT_W'(NUM_OUT - 1);
  assign pop_o     = q_valid_i && (!busy_q || (emit && last_beat));

  // Wheel position of this LED, wrapped once.
  assign sum = {1'b0, PHASE_W'(idx_q)} + {1'b0, phase_q};
  always_comb begin
    if (sum >= (PHASE_W + 1)'(LED_COUNT)) begin
      x = PHASE_W'(sum - (PHASE_W + 1)'(LED_COUNT));
    end else begin
      x = sum[PHASE_W-1:0];
    end
  end

  assign sec = sec_tbl[x];
  assign f   = frac_tbl[x];

  always_comb begin
    case (sec)
      3'd1:    begin rr = FULL - f; gg = FULL;     bb = '0;       end
      3'd2:    begin rr = '0;       gg = FULL;     bb = f;        end
      3'd3:    begin rr = '0;       gg = FULL - f; bb = FULL;     end
      3'd4:    begin rr = f;        gg = '0;       bb = FULL;     end
      3'd5:    begin rr = FULL;     gg = '0;       bb = FULL - f; end
      default: begin rr = FULL;     gg = f;        bb = '0;       end
    endcase
  end

  always_comb begin
    r_c = '0;
    g_c = '0;
    b_c = '0;
    if (pattern_i == PAT_RAINBOW) begin
      r_c = rr >> shift_i;
      g_c = gg >> shift_i;
      b_c = bb >> shift_i;
    end else if (x < PHASE_W'(5)) begin
      r_c = FULL;
    end else if (x < PHASE_W'(10)) begin
      g_c = FULL;
    end else if (x < PHASE_W'(15)) begin
      b_c = FULL;
    end
  end

  always_comb begin
    busy_d  = busy_q;
    idx_d   = idx_q;
    phase_d = phase_q;
    if (emit) begin
      if (last_beat) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
    if (pop_o) begin
      busy_d  = 1'b1;
      idx_d   = '0;
      phase_d = q_phase_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      idx_q     <= '0;
      phase_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      idx_q   <= idx_d;
      phase_q <= phase_d;
      if (advance) begin
        out_vld_q <= busy_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      idx_out_q <= LED_IDX_W'(idx_q);
      r_q       <= r_c;
      g_q       <= g_c;
      b_q       <= b_c;
      last_q    <= last_beat;
    end
  end

  assign out_valid_o = out_vld_q;
  assign led_index_o = idx_out_q;
  assign red_o       = r_q;
  assign green_o     = g_q;
  assign blue_o      = b_q;
  assign last_led_o  = last_q;

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> idx_q <= CNT_W'(NUM_OUT - 1))
    else $error("LED counter past frame end");
  a_last_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && last_q) |-> idx_out_q == LED_IDX_W'(NUM_OUT - 1))
    else $error("last flag on wrong LED");
  a_pop_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (busy_q && idx_q == '0))
    else $error("popped frame did not start");
`endif

endmodule

@@ tb/sv/led_backlight_pattern_generator_tb.sv @@
// Testbench for led_backlight_pattern_generator: directed and random time stamps,
// config sweeps, a frame-by-frame color predictor and an in-order beat checker.
// Depends on lbpg_pkg and the generator RTL only.
`timescale 1ns / 100ps

module led_backlight_pattern_generator_tb;
  import lbpg_pkg::*;

  localparam int unsigned LEDS           = LED_COUNT_DEF;
  localparam int unsigned FRAME_BEATS    = (LEDS < MAX_RESULTS) ? LEDS : MAX_RESULTS;
  localparam int unsigned SNAKE_BAND     = 5;
  localparam int unsigned CH_MAX         = 255;
  localparam int unsigned HOLDOFF_CYCLES = 8;
  localparam int unsigned WATCHDOG_LIMIT = 4000;  // quiet cycles before giving up
  localparam int unsigned RESET_CYCLES   = 12;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam int unsigned RANDOM_PHASES  = 8;
  localparam int unsigned PHASE_BEATS    = 26;
  localparam logic [INTERVAL_W-1:0] INTERVAL_TOP = 20'd1000000;
  localparam logic [INTERVAL_W-1:0] INTERVAL_ALL = 20'hFFFFF;

  // Six hue sectors, named by the channel that ramps within them.
  typedef enum int unsigned {
    SEC_GREEN_UP, SEC_RED_DOWN, SEC_BLUE_UP, SEC_GREEN_DOWN, SEC_RED_UP, SEC_BLUE_DOWN
  } hue_sector_e;

  // Receiver back-pressure styles.
  typedef enum int unsigned {RDY_ALWAYS, RDY_RANDOM, RDY_PERIODIC, RDY_SPARSE} rdy_mode_e;

  typedef struct packed {
    logic [LED_IDX_W-1:0] led_idx;
    logic [CH_W-1:0]      red;
    logic [CH_W-1:0]      green;
    logic [CH_W-1:0]      blue;
    logic                 last;
  } led_beat_t;

  // Frame scoreboard: mirrors the registers and animation state, expands each
  // accepted time stamp into the LED colors it should produce, and checks the
  // output beats against them in order.
  class led_frame_scoreboard;
    logic                  pattern;
    logic [SHIFT_W-1:0]    shift;
    logic [INTERVAL_W-1:0] interval_us;
    logic [TIME_W-1:0]     last_frame_us;
    int unsigned           phase;
    led_beat_t             frame_queue[$];
    int unsigned           errors;

    function new();
      pattern       = PATTERN_RST;
      shift         = SHIFT_RST;
      interval_us   = INTERVAL_RST;
      last_frame_us = '0;
      phase         = 0;
      errors        = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_PATTERN:  pattern     = data[0];
        CFG_SHIFT:    shift       = data[SHIFT_W-1:0];
        CFG_INTERVAL: interval_us = data[INTERVAL_W-1:0];
        default: ;
      endcase
    endfunction

    function void hue_color(int unsigned x, output led_beat_t b);
      int unsigned p;
      int unsigned f;
      int unsigned rr;
      int unsigned gg;
      int unsigned bb;
      p = x * 6;
      f = (CH_MAX * (p % LEDS)) / LEDS;
      case (hue_sector_e'(p / LEDS))
        SEC_RED_DOWN:   begin rr = CH_MAX - f; gg = CH_MAX;     bb = 0;          end
        SEC_BLUE_UP:    begin rr = 0;          gg = CH_MAX;     bb = f;          end
        SEC_GREEN_DOWN: begin rr = 0;          gg = CH_MAX - f; bb = CH_MAX;     end
        SEC_RED_UP:     begin rr = f;          gg = 0;          bb = CH_MAX;     end
        SEC_BLUE_DOWN:  begin rr = CH_MAX;     gg = 0;          bb = CH_MAX - f; end
        default:        begin rr = CH_MAX;     gg = f;          bb = 0;          end
      endcase
      b.red   = CH_W'(rr >> shift);
      b.green = CH_W'(gg >> shift);
      b.blue  = CH_W'(bb >> shift);
    endfunction

    function void snake_color(int unsigned x, output led_beat_t b);
      b.red   = (x < SNAKE_BAND) ? CH_W'(CH_MAX) : '0;
      b.green = (x >= SNAKE_BAND && x < 2 * SNAKE_BAND) ? CH_W'(CH_MAX) : '0;
      b.blue  = (x >= 2 * SNAKE_BAND && x < 3 * SNAKE_BAND) ? CH_W'(CH_MAX) : '0;
    endfunction

    // Note one accepted time stamp; queue a whole frame if the interval elapsed.
    function void note_beat(logic [TIME_W-1:0] now, logic sent);
      led_beat_t   b;
      int unsigned x;
      if (now - last_frame_us < TIME_W'(interval_us)) return;
      last_frame_us = now;
      for (int unsigned i = 0; i < FRAME_BEATS; i++) begin
        x = (i + phase) % LEDS;
        if (pattern == PAT_RAINBOW) hue_color(x, b);
        else snake_color(x, b);
        b.led_idx = LED_IDX_W'(i);
        b.last    = (i == FRAME_BEATS - 1);
        frame_queue.push_back(b);
      end
      if (sent) phase = (phase + 1) % LEDS;
    endfunction

    function void check_beat(led_beat_t got);
      led_beat_t exp_b;
      if (frame_queue.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected beat led=%0d rgb=%02h/%02h/%02h last=%0b", $realtime,
                   got.led_idx, got.red, got.green, got.blue, got.last);
        return;
      end
      exp_b = frame_queue.pop_front();
      if (got !== exp_b) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display({"%0t: mismatch exp led=%0d rgb=%02h/%02h/%02h last=%0b,",
                    " got led=%0d rgb=%02h/%02h/%02h last=%0b"},
                   $realtime, exp_b.led_idx, exp_b.red, exp_b.green, exp_b.blue, exp_b.last,
                   got.led_idx, got.red, got.green, got.blue, got.last);
      end
    endfunction

    function int unsigned pending_count();
      return frame_queue.size();
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_PATTERN;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  logic [TIME_W-1:0]     now_us_i    = '0;
  logic                  frame_sent_i = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [LED_IDX_W-1:0]  led_index_o;
  logic [CH_W-1:0]       red_o;
  logic [CH_W-1:0]       green_o;
  logic [CH_W-1:0]       blue_o;
  logic                  last_led_o;

  led_frame_scoreboard sb = new();

  int unsigned burst_left = 0;
  rdy_mode_e   rdy_mode   = RDY_ALWAYS;
  int unsigned mode_left  = 0;
  int unsigned rdy_tick   = 0;
  int unsigned quiet      = 0;

  led_backlight_pattern_generator uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .now_us_i     (now_us_i),
    .frame_sent_i (frame_sent_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .led_index_o  (led_index_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .last_led_o   (last_led_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Receiver: switch among back-pressure styles at random times so that
  // stalls land on every LED position, with stretches of no stall at all.
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      rdy_mode  = rdy_mode_e'($urandom_range(0, 3));
      mode_left = $urandom_range(20, 150);
    end else begin
      mode_left--;
    end
    rdy_tick++;
    case (rdy_mode)
      RDY_RANDOM:   out_ready_i <= ($urandom_range(0, 3) != 0);
      RDY_PERIODIC: out_ready_i <= (rdy_tick % 5 < 2);
      RDY_SPARSE:   out_ready_i <= ($urandom_range(0, 7) == 0);
      default:      out_ready_i <= 1'b1;
    endcase
  end

  // Check every output beat taken by the receiver.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_beat('{led_index_o, red_o, green_o, blue_o, last_led_o});
  end

  // Watchdog: end the run if no beat moves on any port for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i)
      quiet = 0;
    else
      quiet++;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("FAIL led_backlight_pattern_generator");
      $finish;
    end
  end

  // Present one time stamp and hold it until accepted. The sender runs in bursts;
  // between bursts valid drops for a random gap, sometimes a long one.
  task automatic send_beat(input logic [TIME_W-1:0] now, input logic sent);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    now_us_i     <= now;
    frame_sent_i <= sent;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_beat(now, sent);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, data);
  endtask

  // Drop valid, drain every expected beat, then hold off so that a time stamp
  // that produced no frame has surely left the front end.
  task automatic settle_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    burst_left = 0;
    while (sb.pending_count() != 0) @(posedge clk_i);
    repeat (HOLDOFF_CYCLES) @(posedge clk_i);
  endtask

  function automatic logic [INTERVAL_W-1:0] pick_interval();
    case ($urandom_range(0, 6))
      0:       return '0;
      1:       return INTERVAL_W'(1);
      2:       return INTERVAL_W'($urandom_range(1, 64));
      3:       return INTERVAL_W'($urandom_range(100, 40000));
      4:       return INTERVAL_TOP;
      5:       return INTERVAL_ALL;
      default: return INTERVAL_W'($urandom_range(0, INTERVAL_ALL));
    endcase
  endfunction

  // Mostly well-timed stamps (frame due), some early ones, some arbitrary
  // 64-bit values that jump forward or back in time.
  task automatic random_phase(input int unsigned beats);
    int unsigned       kind;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] iv;
    for (int unsigned k = 0; k < beats; k++) begin
      kind = $urandom_range(0, 99);
      iv   = TIME_W'(sb.interval_us);
      if (kind < 60)
        now = sb.last_frame_us + iv + (($urandom_range(0, 1) != 0) ? 0 : $urandom_range(0, 1000));
      else if (kind < 80)
        now = sb.last_frame_us + ((iv == 0) ? 0 : $urandom_range(0, int'(iv) - 1));
      else
        now = {$urandom, $urandom};
      send_beat(now, $urandom_range(0, 3) != 0);
    end
  endtask

  initial begin
    logic [TIME_W-1:0] t0;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset config: rainbow, shift 3, 33 ms interval. Cover too-early stamps,
    // exact-interval triggers, phase hold vs advance, and time going backwards.
    send_beat(64'd0, 1'b1);
    send_beat(64'd32999, 1'b1);
    send_beat(64'd33000, 1'b0);
    send_beat(64'd66000, 1'b1);
    send_beat(64'd66001, 1'b1);
    send_beat('1, 1'b1);
    send_beat(64'd100000, 1'b1);
    send_beat(64'd50, 1'b0);

    // Zero interval: every stamp makes a frame, even a repeated or older one.
    settle_idle();
    write_reg(CFG_INTERVAL, '0);
    write_reg(CFG_SHIFT, CFG_DATA_W'(7));
    send_beat(64'd50, 1'b1);
    send_beat(64'd0, 1'b1);
    send_beat(64'd0, 1'b0);

    // Snake bands; the brightness shift must not apply.
    settle_idle();
    write_reg(CFG_PATTERN, CFG_DATA_W'(PAT_SNAKE));
    send_beat(64'd5, 1'b1);
    send_beat(64'd6, 1'b1);
    send_beat(64'd7, 1'b0);

    // Full brightness rainbow at the INTERVAL_TOP interval.
    settle_idle();
    write_reg(CFG_PATTERN, CFG_DATA_W'(PAT_RAINBOW));
    write_reg(CFG_SHIFT, '0);
    write_reg(CFG_INTERVAL, CFG_DATA_W'(INTERVAL_TOP));
    t0 = sb.last_frame_us;
    send_beat(t0 + 64'd999999, 1'b1);
    send_beat(t0 + 64'd1000000, 1'b1);
    send_beat(t0 + 64'd2000000, 1'b0);

    // Random phases, each with a fresh register setting.
    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle_idle();
      write_reg(CFG_PATTERN, CFG_DATA_W'($urandom_range(0, 1)));
      write_reg(CFG_SHIFT, CFG_DATA_W'($urandom_range(0, 7)));
      write_reg(CFG_INTERVAL, CFG_DATA_W'(pick_interval()));
      random_phase(PHASE_BEATS);
    end

    settle_idle();
    if (sb.errors == 0 && sb.pending_count() == 0)
      $display("PASS led_backlight_pattern_generator");
    else
      $display("FAIL led_backlight_pattern_generator");
    $finish;
  end

endmodule
